FILE: sv/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants shared by the frequency-ordered key-value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;
	localparam int DATA_W      = 32;

	localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
	localparam logic [DATA_W-1:0]        COUNT_MAX  = 32'hFFFF_FFFF;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_TOUCH,
		UPD_INSERT
	} upd_t;

	typedef struct packed {
		logic busy;
		logic scan_clr;
		logic scan_vld;
		logic decide;
		logic sweep_vld;
		logic done;
	} ctrl_t;

	typedef struct packed {
		logic hit;
		logic victim;
		logic free;
	} scan_flags_t;

endpackage

FILE: sv/lfu_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_slot_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfu_slot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int WIDTH = 100
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/lfu_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_scan
// Shared compare unit: one slot per cycle, tracks key match, eviction
// victim (lowest count, then oldest) and first free slot.
// ----------------------------------------------------------------------------
module lfu_scan
	import lfu_pkg::*;
#(
	parameter int IW = 4,
	parameter int RW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              vld,
	input  logic [IW-1:0]     idx,
	input  logic              slot_valid,
	input  logic [DATA_W-1:0] slot_key,
	input  logic [DATA_W-1:0] slot_value,
	input  logic [DATA_W-1:0] slot_count,
	input  logic [RW-1:0]     slot_rank,
	input  logic [DATA_W-1:0] match_key,
	output scan_flags_t       flags,
	output logic [IW-1:0]     found_idx,
	output logic [DATA_W-1:0] found_value,
	output logic [RW-1:0]     found_rank,
	output logic [IW-1:0]     victim_idx,
	output logic [DATA_W-1:0] victim_key,
	output logic [RW-1:0]     victim_rank,
	output logic [IW-1:0]     free_idx
);

	scan_flags_t       flags_q;
	logic [IW-1:0]     found_idx_q;
	logic [DATA_W-1:0] found_value_q;
	logic [RW-1:0]     found_rank_q;
	logic [IW-1:0]     victim_idx_q;
	logic [DATA_W-1:0] victim_key_q;
	logic [DATA_W-1:0] victim_cnt_q;
	logic [RW-1:0]     victim_rank_q;
	logic [IW-1:0]     free_idx_q;

	logic take_hit;
	logic take_victim;
	logic take_free;

	always_comb begin
		take_hit    = vld && slot_valid && !flags_q.hit && (slot_key == match_key);
		take_victim = vld && slot_valid && (!flags_q.victim || (slot_count < victim_cnt_q) ||
			((slot_count == victim_cnt_q) && (slot_rank > victim_rank_q)));
		take_free   = vld && !slot_valid && !flags_q.free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else begin
			if (take_hit)    flags_q.hit    <= 1'b1;
			if (take_victim) flags_q.victim <= 1'b1;
			if (take_free)   flags_q.free   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			found_idx_q   <= idx;
			found_value_q <= slot_value;
			found_rank_q  <= slot_rank;
		end
		if (take_victim) begin
			victim_idx_q  <= idx;
			victim_key_q  <= slot_key;
			victim_cnt_q  <= slot_count;
			victim_rank_q <= slot_rank;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	assign flags       = flags_q;
	assign found_idx   = found_idx_q;
	assign found_value = found_value_q;
	assign found_rank  = found_rank_q;
	assign victim_idx  = victim_idx_q;
	assign victim_key  = victim_key_q;
	assign victim_rank = victim_rank_q;
	assign free_idx    = free_idx_q;

endmodule

FILE: sv/lfu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: scan pass over all slots, decision, optional update sweep,
// result strobe.
// ----------------------------------------------------------------------------
module lfu_ctrl
	import lfu_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IW      = 4,
	parameter int CW      = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          need_sweep,
	output ctrl_t         ctrl,
	output logic [IW-1:0] raddr,
	output logic [IW-1:0] idx
);

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] cnt_q;
	logic          issue;
	logic          last;
	logic          issue_s1;
	logic [IW-1:0] idx_s1;

	assign last  = (cnt_q == CW'(ENTRIES));
	assign issue = (state_q inside {ST_SCAN, ST_SWEEP}) && !last;
	assign raddr = cnt_q[IW-1:0];
	assign idx   = idx_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (last) state_d = ST_DECIDE;
			ST_DECIDE: state_d = need_sweep ? ST_SWEEP : ST_DONE;
			ST_SWEEP:  if (last) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.busy      = (state_q != ST_IDLE);
		ctrl.scan_clr  = (state_q == ST_IDLE);
		ctrl.scan_vld  = (state_q == ST_SCAN) && issue_s1;
		ctrl.decide    = (state_q == ST_DECIDE);
		ctrl.sweep_vld = (state_q == ST_SWEEP) && issue_s1;
		ctrl.done      = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			issue_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q inside {ST_IDLE, ST_DECIDE}) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
	end

endmodule

FILE: sv/lfu_cache_policy_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_policy_top
// Key-value cache, least-frequently-used eviction with recency tie-break.
// ----------------------------------------------------------------------------
//  port group            dir   handshake
//  start / req           in    accepted when start && !busy
//  done / rsp            out   one-cycle strobe, cannot be held off
//  cfg_we / cfg_wdata    in    capacity written when cfg_we
//
//  a request that changes nothing (get miss, put at zero capacity) makes one
//  pass of the shared compare unit over the slot ram; any other request then
//  makes one read-modify-write pass over the same ram, through its read and
//  write ports, to age ranks and write the touched slot
//  busy is high from acceptance through the result strobe
//  reset clears all valid bits at once and restores capacity to 16
// ----------------------------------------------------------------------------
module lfu_cache_policy_top
	import lfu_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = IW;
	localparam int WW = 3 * DATA_W + RW;
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;

	ctrl_t             ctrl;
	logic [IW-1:0]     raddr;
	logic [IW-1:0]     idx_s1;
	logic              need_sweep;

	logic [CAP_W-1:0]  cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]     occ_q;
	req_t              req_q;
	rsp_t              rsp_q;
	upd_t              upd_q;
	logic [IW-1:0]     tgt_q;
	logic              evict_q;
	logic [RW-1:0]     rref_q;

	logic [WW-1:0]     rdata;
	logic [WW-1:0]     wdata;
	logic              we;
	logic [DATA_W-1:0] s_key;
	logic [DATA_W-1:0] s_value;
	logic [DATA_W-1:0] s_count;
	logic [RW-1:0]     s_rank;
	logic              s_valid;

	scan_flags_t       flags;
	logic [IW-1:0]     found_idx;
	logic [DATA_W-1:0] found_value;
	logic [RW-1:0]     found_rank;
	logic [IW-1:0]     victim_idx;
	logic [DATA_W-1:0] victim_key;
	logic [RW-1:0]     victim_rank;
	logic [IW-1:0]     free_idx;

	rsp_t              rsp_d;
	upd_t              upd_d;
	logic [IW-1:0]     tgt_d;
	logic              evict_d;
	logic [RW-1:0]     rref_d;
	logic              set_valid;
	logic              inc_occ;
	logic [MW-1:0]     cap_ext;
	logic [MW-1:0]     cap_eff;
	logic [MW-1:0]     occ_ext;

	logic              accept;

	assign accept = start && !ctrl.busy;
	assign busy   = ctrl.busy;
	assign done   = ctrl.done;
	assign rsp    = rsp_q;

	lfu_ctrl #(
		.ENTRIES (ENTRIES),
		.IW      (IW),
		.CW      (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.need_sweep (need_sweep),
		.ctrl       (ctrl),
		.raddr      (raddr),
		.idx        (idx_s1)
	);

	lfu_slot_ram #(
		.DEPTH (ENTRIES),
		.AW    (IW),
		.WIDTH (WW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign {s_key, s_value, s_count, s_rank} = rdata;
	assign s_valid = valid_q[idx_s1];

	lfu_scan #(
		.IW (IW),
		.RW (RW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (ctrl.scan_clr),
		.vld         (ctrl.scan_vld),
		.idx         (idx_s1),
		.slot_valid  (s_valid),
		.slot_key    (s_key),
		.slot_value  (s_value),
		.slot_count  (s_count),
		.slot_rank   (s_rank),
		.match_key   (req_q.key),
		.flags       (flags),
		.found_idx   (found_idx),
		.found_value (found_value),
		.found_rank  (found_rank),
		.victim_idx  (victim_idx),
		.victim_key  (victim_key),
		.victim_rank (victim_rank),
		.free_idx    (free_idx)
	);

	// decision after the scan pass
	always_comb begin
		cap_ext   = MW'(cap_q);
		cap_eff   = (cap_ext > MW'(ENTRIES)) ? MW'(ENTRIES) : cap_ext;
		occ_ext   = MW'(occ_q);
		rsp_d     = '0;
		rsp_d.hit = flags.hit;
		upd_d     = UPD_NONE;
		tgt_d     = found_idx;
		evict_d   = 1'b0;
		rref_d    = found_rank;
		set_valid = 1'b0;
		inc_occ   = 1'b0;
		if (req_q.action == ACT_GET) begin
			if (flags.hit) begin
				rsp_d.read_value = found_value;
				upd_d            = UPD_TOUCH;
			end else begin
				rsp_d.read_value = MISS_VALUE;
			end
		end else if (cap_eff != '0) begin
			if (flags.hit) begin
				upd_d = UPD_TOUCH;
			end else if ((occ_ext >= cap_eff) && flags.victim) begin
				upd_d             = UPD_INSERT;
				tgt_d             = victim_idx;
				evict_d           = 1'b1;
				rref_d            = victim_rank;
				rsp_d.evicted     = 1'b1;
				rsp_d.evicted_key = victim_key;
			end else if (flags.free) begin
				upd_d     = UPD_INSERT;
				tgt_d     = free_idx;
				set_valid = 1'b1;
				inc_occ   = 1'b1;
			end
		end
	end

	assign need_sweep = (upd_d != UPD_NONE);

	// update sweep: age ranks and rewrite the target slot
	always_comb begin
		we    = 1'b0;
		wdata = rdata;
		if (ctrl.sweep_vld) begin
			if (idx_s1 == tgt_q) begin
				we = 1'b1;
				if (upd_q == UPD_INSERT) begin
					wdata = {req_q.key, req_q.value, DATA_W'(1), RW'(0)};
				end else begin
					wdata = {s_key,
						(req_q.action == ACT_PUT) ? req_q.value : s_value,
						(s_count == COUNT_MAX) ? s_count : s_count + 1'b1,
						RW'(0)};
				end
			end else if (s_valid) begin
				we = 1'b1;
				if (upd_q == UPD_INSERT) begin
					wdata = {s_key, s_value, s_count,
						((evict_q && (s_rank > rref_q)) ? s_rank - 1'b1 : s_rank) + 1'b1};
				end else begin
					wdata = {s_key, s_value, s_count,
						(s_rank < rref_q) ? s_rank + 1'b1 : s_rank};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			valid_q <= '0;
			occ_q   <= '0;
			upd_q   <= UPD_NONE;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctrl.decide) begin
				upd_q <= upd_d;
				if (set_valid) valid_q[tgt_d] <= 1'b1;
				if (inc_occ)   occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (ctrl.decide) begin
			rsp_q   <= rsp_d;
			tgt_q   <= tgt_d;
			evict_q <= evict_d;
			rref_q  <= rref_d;
		end
	end

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) == $countones(valid_q))
		else $error("occupancy differs from valid bit count");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.evicted |-> !rsp.hit && (req_q.action == ACT_PUT))
		else $error("eviction reported on hit or get");

	a_done_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result strobe");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request not taken up");

endmodule
